FILE: hw/rtl/sstl_pkg.sv
// Package for the session state table with locks.
// Holds field widths, the CLOSED code, beat layouts and the per-beat operation struct.
// No dependencies.
package sstl_pkg;

	localparam int SESSION_W = 5;
	localparam int STATE_W   = 4;
	localparam int IN_W      = 40;
	localparam int OUT_W     = 32;
	localparam int TBL_SPAN  = 2 ** SESSION_W;

	localparam logic [STATE_W-1:0] CLOSED = 4'd0;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_TX,
		RD_STREAM,
		RD_RX
	} rd_port_t;

	// Input beat, last field in the lowest bits.
	typedef struct packed {
		logic [5:0]           pad;
		logic [SESSION_W-1:0] close_session;
		logic                 close_valid;
		logic [STATE_W-1:0]   rx_new_state;
		logic                 rx_is_write;
		logic [SESSION_W-1:0] rx_session;
		logic                 rx_valid;
		logic [SESSION_W-1:0] stream_session;
		logic                 stream_valid;
		logic [STATE_W-1:0]   tx_new_state;
		logic                 tx_is_write;
		logic [SESSION_W-1:0] tx_session;
		logic                 tx_valid;
	} sstl_in_t;

	// Result beat, last field in the lowest bits.
	typedef struct packed {
		logic [6:0]           pad;
		logic [SESSION_W-1:0] release_session;
		logic                 release_valid;
		logic [STATE_W-1:0]   rx_reply_state;
		logic                 rx_reply_valid;
		logic [STATE_W-1:0]   stream_reply_state;
		logic                 stream_reply_valid;
		logic [STATE_W-1:0]   tx_reply_state;
		logic                 tx_reply_valid;
		logic                 close_taken;
		logic                 rx_taken;
		logic                 stream_taken;
		logic                 tx_taken;
	} sstl_out_t;

	// Parked connect or receive request.
	typedef struct packed {
		logic [STATE_W-1:0]   state;
		logic                 is_write;
		logic [SESSION_W-1:0] session;
	} sstl_req_t;

	// What the arbiter decided for one beat.
	typedef struct packed {
		logic                 tx_taken;
		logic                 stream_taken;
		logic                 rx_taken;
		logic                 close_taken;
		rd_port_t             rd_port;
		logic [SESSION_W-1:0] rd_session;
		logic                 wr_en;
		logic [SESSION_W-1:0] wr_session;
		logic [STATE_W-1:0]   wr_state;
		logic                 release_valid;
		logic [SESSION_W-1:0] release_session;
	} sstl_op_t;

endpackage

FILE: hw/rtl/sstl_arbiter.sv
// Fixed-priority arbiter with the lock and wait registers of the session table.
// Depends on sstl_pkg; decides one table operation per accepted beat.
module sstl_arbiter import sstl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  sstl_in_t req,
	output sstl_op_t op
);

	logic                 tx_waiting_q, rx_waiting_q, close_waiting_q;
	logic                 tx_locked_q, rx_locked_q;
	logic [SESSION_W-1:0] tx_lock_session_q, rx_lock_session_q;
	sstl_req_t            held_tx_q, held_rx_q;
	logic [SESSION_W-1:0] held_close_q;

	logic                 tx_waiting_d, rx_waiting_d, close_waiting_d;
	logic                 tx_locked_d, rx_locked_d;
	logic [SESSION_W-1:0] tx_lock_session_d, rx_lock_session_d;
	sstl_req_t            held_tx_d, held_rx_d;
	logic [SESSION_W-1:0] held_close_d;

	sstl_req_t            new_tx, new_rx;
	logic                 do_tx, do_rx, do_close;
	sstl_req_t            tx_sel, rx_sel;
	logic [SESSION_W-1:0] close_sel;

	assign new_tx = '{state: req.tx_new_state, is_write: req.tx_is_write,
		session: req.tx_session};
	assign new_rx = '{state: req.rx_new_state, is_write: req.rx_is_write,
		session: req.rx_session};

	function automatic logic close_blocked(
		input logic [SESSION_W-1:0] s,
		input logic rxl, input logic [SESSION_W-1:0] rxs,
		input logic txl, input logic [SESSION_W-1:0] txs);
		return (rxl && s == rxs) || (txl && s == txs);
	endfunction

	always_comb begin
		op                = '0;
		op.rd_port        = RD_NONE;
		tx_waiting_d      = tx_waiting_q;
		rx_waiting_d      = rx_waiting_q;
		close_waiting_d   = close_waiting_q;
		tx_locked_d       = tx_locked_q;
		rx_locked_d       = rx_locked_q;
		tx_lock_session_d = tx_lock_session_q;
		rx_lock_session_d = rx_lock_session_q;
		held_tx_d         = held_tx_q;
		held_rx_d         = held_rx_q;
		held_close_d      = held_close_q;
		do_tx             = 1'b0;
		do_rx             = 1'b0;
		do_close          = 1'b0;
		tx_sel            = held_tx_q;
		rx_sel            = held_rx_q;
		close_sel         = held_close_q;

		if (req.tx_valid && !tx_waiting_q) begin
			op.tx_taken = 1'b1;
			held_tx_d   = new_tx;
			tx_sel      = new_tx;
			if (rx_locked_q && new_tx.session == rx_lock_session_q) tx_waiting_d = 1'b1;
			else do_tx = 1'b1;
		end else if (req.stream_valid) begin
			op.stream_taken = 1'b1;
			op.rd_port      = RD_STREAM;
			op.rd_session   = req.stream_session;
		end else if (req.rx_valid && !rx_waiting_q) begin
			op.rx_taken = 1'b1;
			held_rx_d   = new_rx;
			rx_sel      = new_rx;
			if (tx_locked_q && new_rx.session == tx_lock_session_q) rx_waiting_d = 1'b1;
			else do_rx = 1'b1;
		end else if (req.close_valid && !close_waiting_q) begin
			op.close_taken = 1'b1;
			held_close_d   = req.close_session;
			close_sel      = req.close_session;
			if (close_blocked(req.close_session, rx_locked_q, rx_lock_session_q,
					tx_locked_q, tx_lock_session_q)) close_waiting_d = 1'b1;
			else do_close = 1'b1;
		end else if (tx_waiting_q) begin
			if (!rx_locked_q || held_tx_q.session != rx_lock_session_q) begin
				do_tx        = 1'b1;
				tx_waiting_d = 1'b0;
			end
		end else if (rx_waiting_q) begin
			if (!tx_locked_q || held_rx_q.session != tx_lock_session_q) begin
				do_rx        = 1'b1;
				rx_waiting_d = 1'b0;
			end
		end else if (close_waiting_q) begin
			if (!close_blocked(held_close_q, rx_locked_q, rx_lock_session_q,
					tx_locked_q, tx_lock_session_q)) begin
				do_close        = 1'b1;
				close_waiting_d = 1'b0;
			end
		end

		if (do_tx) begin
			if (tx_sel.is_write) begin
				op.wr_en      = 1'b1;
				op.wr_session = tx_sel.session;
				op.wr_state   = tx_sel.state;
				tx_locked_d   = 1'b0;
			end else begin
				op.rd_port        = RD_TX;
				op.rd_session     = tx_sel.session;
				tx_lock_session_d = tx_sel.session;
				tx_locked_d       = 1'b1;
			end
		end

		if (do_rx) begin
			if (rx_sel.is_write) begin
				op.wr_en      = 1'b1;
				op.wr_session = rx_sel.session;
				op.wr_state   = rx_sel.state;
				rx_locked_d   = 1'b0;
				if (rx_sel.state == CLOSED) begin
					op.release_valid   = 1'b1;
					op.release_session = rx_sel.session;
				end
			end else begin
				op.rd_port        = RD_RX;
				op.rd_session     = rx_sel.session;
				rx_lock_session_d = rx_sel.session;
				rx_locked_d       = 1'b1;
			end
		end

		if (do_close) begin
			op.wr_en           = 1'b1;
			op.wr_session      = close_sel;
			op.wr_state        = CLOSED;
			op.release_valid   = 1'b1;
			op.release_session = close_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_waiting_q      <= 1'b0;
			rx_waiting_q      <= 1'b0;
			close_waiting_q   <= 1'b0;
			tx_locked_q       <= 1'b0;
			rx_locked_q       <= 1'b0;
			tx_lock_session_q <= '0;
			rx_lock_session_q <= '0;
			held_tx_q         <= '0;
			held_rx_q         <= '0;
			held_close_q      <= '0;
		end else if (accept) begin
			tx_waiting_q      <= tx_waiting_d;
			rx_waiting_q      <= rx_waiting_d;
			close_waiting_q   <= close_waiting_d;
			tx_locked_q       <= tx_locked_d;
			rx_locked_q       <= rx_locked_d;
			tx_lock_session_q <= tx_lock_session_d;
			rx_lock_session_q <= rx_lock_session_d;
			held_tx_q         <= held_tx_d;
			held_rx_q         <= held_rx_d;
			held_close_q      <= held_close_d;
		end
	end

endmodule

FILE: hw/rtl/sstl_table.sv
// Session state memory: one write port, one registered read port, per-entry valid bits.
// Depends on sstl_pkg; an entry never written, or an index out of range, reads as CLOSED.
module sstl_table import sstl_pkg::*; #(
	parameter int SESSIONS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [SESSION_W-1:0] rd_session,
	input  logic                 wr_en,
	input  logic [SESSION_W-1:0] wr_session,
	input  logic [STATE_W-1:0]   wr_state,
	output logic [STATE_W-1:0]   rd_state
);

	// Only indices the session field can name get storage.
	localparam int DEPTH = (SESSIONS < TBL_SPAN) ? SESSIONS : TBL_SPAN;
	localparam int AW    = $clog2(DEPTH);

	logic [STATE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   valid_q;
	logic [STATE_W-1:0] rd_data_q;
	logic               rd_ok_q;

	logic          rd_in_range, wr_in_range;
	logic [AW-1:0] rd_addr, wr_addr;

	assign rd_in_range = int'(rd_session) < SESSIONS;
	assign wr_in_range = int'(wr_session) < SESSIONS;
	assign rd_addr     = AW'(rd_session);
	assign wr_addr     = AW'(wr_session);

	always_ff @(posedge clk) begin
		if (wr_en && wr_in_range) mem[wr_addr] <= wr_state;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (wr_en && wr_in_range) valid_q[wr_addr] <= 1'b1;
			if (rd_en) rd_ok_q <= rd_in_range && valid_q[rd_addr];
		end
	end

	assign rd_state = rd_ok_q ? rd_data_q : CLOSED;

endmodule

FILE: hw/rtl/session_state_table_with_locks.sv
// Session state table with connect/receive locks, top level; uses sstl_pkg, sstl_arbiter, sstl_table.
// An accepted input beat passes stage 1 and then the output register before its result beat reaches the master side.
// Throughput: one beat per cycle while m_tready holds; the table is read at accept and its registered read
// data joins the result in stage 1, writes land at accept.
// Reset: locks, wait flags and held requests clear; the table reads as CLOSED at once
// through per-entry valid bits, so no clearing pass is needed.
module session_state_table_with_locks import sstl_pkg::*; #(
	parameter int SESSIONS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// Fields from bit 0 up: tx_valid, tx_session[5], tx_is_write, tx_new_state[4],
	// stream_valid, stream_session[5], rx_valid, rx_session[5], rx_is_write,
	// rx_new_state[4], close_valid, close_session[5], zero fill.
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// Fields from bit 0 up: tx_taken, stream_taken, rx_taken, close_taken,
	// tx_reply_valid, tx_reply_state[4], stream_reply_valid, stream_reply_state[4],
	// rx_reply_valid, rx_reply_state[4], release_valid, release_session[5], zero fill.
	output logic [OUT_W-1:0] m_tdata
);

	sstl_in_t           req;
	sstl_op_t           op;
	logic               accept;
	logic               advance;
	logic [STATE_W-1:0] rd_state;

	// Stage 1: decision waiting for the table read data.
	logic               valid_s1;
	sstl_op_t           op_s1;

	// Output register parts the table pipe from the master side.
	logic               out_valid_q;
	sstl_out_t          out_q;
	sstl_out_t          res;

	assign req = sstl_in_t'(s_tdata);

	// Advance stage 1 whenever the output register is free or being drained.
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	sstl_arbiter u_arb (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.op     (op)
	);

	// Read only on accept so a stalled stage 1 keeps its read data.
	sstl_table #(.SESSIONS(SESSIONS)) u_tbl (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (accept && op.rd_port != RD_NONE),
		.rd_session (op.rd_session),
		.wr_en      (accept && op.wr_en),
		.wr_session (op.wr_session),
		.wr_state   (op.wr_state),
		.rd_state   (rd_state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) op_s1 <= op;
	end

	// Assemble the result beat; replies and release are zero when not issued.
	always_comb begin
		res                    = '0;
		res.tx_taken           = op_s1.tx_taken;
		res.stream_taken       = op_s1.stream_taken;
		res.rx_taken           = op_s1.rx_taken;
		res.close_taken        = op_s1.close_taken;
		res.release_valid      = op_s1.release_valid;
		res.release_session    = op_s1.release_session;
		case (op_s1.rd_port)
			RD_TX: begin
				res.tx_reply_valid = 1'b1;
				res.tx_reply_state = rd_state;
			end
			RD_STREAM: begin
				res.stream_reply_valid = 1'b1;
				res.stream_reply_state = rd_state;
			end
			RD_RX: begin
				res.rx_reply_valid = 1'b1;
				res.rx_reply_state = rd_state;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_q);

`ifndef SYNTHESIS
	// Only one request is served per beat.
	a_one_taken: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones({out_q.tx_taken, out_q.stream_taken,
			out_q.rx_taken, out_q.close_taken}) <= 1)
		else $error("more than one request taken in a beat");

	// A served operation yields at most one reply or one release.
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones({out_q.tx_reply_valid, out_q.stream_reply_valid,
			out_q.rx_reply_valid, out_q.release_valid}) <= 1)
		else $error("more than one reply or release in a beat");

	// Hold stage 1 while the output register is blocked.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(op_s1) && $stable(rd_state)))
		else $error("stage 1 changed while stalled");
`endif

endmodule
